// ===== rtl/assert_macros.svh =====
// assertion macros for the checker file
// clocked on aclk, with and without the synchronous reset as a disable
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define PPP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// property checked at every edge, reset included
`define PPP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/ppp_pkg.sv =====
// shared types, widths and register codes of the point projector
// no dependencies
package ppp_pkg;

    localparam int PT_W     = 20;   // world coordinate
    localparam int TRIG_W   = 16;   // q1.14 cosine / sine
    localparam int VD_W     = 16;   // viewer distance
    localparam int CFG_W    = 20;   // widest register
    localparam int FRAC     = 14;
    localparam int DIFF_W   = PT_W + 1;          // point minus camera
    localparam int PROD_W   = DIFF_W + TRIG_W;   // difference times trig
    localparam int ROT_W    = PROD_W + 1;        // rotated x / z, q14
    localparam int ZP_W     = ROT_W + TRIG_W;    // rotated z times pitch trig
    localparam int SUM_W    = ZP_W + 1;          // q28 sums before the shift
    localparam int DEP_W    = 40;                // y and depth back in q14
    localparam int NUM_W    = 58;                // dividend magnitude
    localparam int QUO_B    = 18;                // quotient bits before saturation
    localparam int OSUM_W   = QUO_B + 3;         // signed quotient plus center
    localparam int OUT_W    = 16;

    localparam int SCREEN_WIDTH_DEF  = 640;
    localparam int SCREEN_HEIGHT_DEF = 480;

    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_COS_YAW   = 3'd0;
    localparam reg_idx_t REG_SIN_YAW   = 3'd1;
    localparam reg_idx_t REG_COS_PITCH = 3'd2;
    localparam reg_idx_t REG_SIN_PITCH = 3'd3;
    localparam reg_idx_t REG_CAM_X     = 3'd4;
    localparam reg_idx_t REG_CAM_Y     = 3'd5;
    localparam reg_idx_t REG_CAM_Z     = 3'd6;
    localparam reg_idx_t REG_VIEW_DIST = 3'd7;

    typedef struct packed {
        logic signed [TRIG_W-1:0] cos_yaw;
        logic signed [TRIG_W-1:0] sin_yaw;
        logic signed [TRIG_W-1:0] cos_pitch;
        logic signed [TRIG_W-1:0] sin_pitch;
        logic signed [PT_W-1:0]   cam_x;
        logic signed [PT_W-1:0]   cam_y;
        logic signed [PT_W-1:0]   cam_z;
        logic [VD_W-1:0]          view_dist;
    } cfg_t;

    // per item flags carried beside the divider
    typedef struct packed {
        logic bad;      // depth zero or negative
        logic zero;     // depth exactly zero
        logic neg_x;    // quotient x negative
        logic neg_y;    // quotient y negative
        logic ovf_x;    // |qx| beyond the quotient bits
        logic ovf_y;
    } side_t;

endpackage

// ===== rtl/ppp_rot.sv =====
// camera offset and yaw / pitch rotation, five register stages
// depends on ppp_pkg
module ppp_rot (
    input  logic                              clk,
    input  logic                              rstn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [ppp_pkg::PT_W-1:0]   px,
    input  logic signed [ppp_pkg::PT_W-1:0]   py,
    input  logic signed [ppp_pkg::PT_W-1:0]   pz,
    input  ppp_pkg::cfg_t                     cfg,
    output logic                              out_valid,
    output logic signed [ppp_pkg::ROT_W-1:0]  xr,
    output logic signed [ppp_pkg::DEP_W-1:0]  yr,
    output logic signed [ppp_pkg::DEP_W-1:0]  dr
);
    import ppp_pkg::*;

    logic [4:0] v_reg;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic signed [PROD_W-1:0] xcy_reg, zsy_reg, xsy_reg, zcy_reg, ycp_reg, ysp_reg;
    logic signed [ROT_W-1:0]  xr3_reg, zr3_reg;
    logic signed [PROD_W-1:0] ycp3_reg, ysp3_reg;
    logic signed [ZP_W-1:0]   zsp_reg, zcp_reg;
    logic signed [ROT_W-1:0]  xr4_reg;
    logic signed [PROD_W-1:0] ycp4_reg, ysp4_reg;
    logic signed [ROT_W-1:0]  xr5_reg;
    logic signed [DEP_W-1:0]  yr5_reg, dr5_reg;

    logic signed [SUM_W-1:0]  ysum, dsum;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    // q28 sums, arithmetic shift is the floor
    always_comb begin
        ysum = (SUM_W'(ycp4_reg) <<< FRAC) + SUM_W'(zsp_reg);
        dsum = SUM_W'(zcp_reg) - (SUM_W'(ysp4_reg) <<< FRAC);
    end

    always_ff @(posedge clk) begin
        if (en) begin
            // offset
            dx_reg   <= DIFF_W'(px) - DIFF_W'(cfg.cam_x);
            dy_reg   <= DIFF_W'(py) - DIFF_W'(cfg.cam_y);
            dz_reg   <= DIFF_W'(pz) - DIFF_W'(cfg.cam_z);
            // yaw products and the pitch products of y
            xcy_reg  <= PROD_W'(dx_reg) * PROD_W'(cfg.cos_yaw);
            zsy_reg  <= PROD_W'(dz_reg) * PROD_W'(cfg.sin_yaw);
            xsy_reg  <= PROD_W'(dx_reg) * PROD_W'(cfg.sin_yaw);
            zcy_reg  <= PROD_W'(dz_reg) * PROD_W'(cfg.cos_yaw);
            ycp_reg  <= PROD_W'(dy_reg) * PROD_W'(cfg.cos_pitch);
            ysp_reg  <= PROD_W'(dy_reg) * PROD_W'(cfg.sin_pitch);
            // yaw sums
            xr3_reg  <= ROT_W'(xcy_reg) - ROT_W'(zsy_reg);
            zr3_reg  <= ROT_W'(xsy_reg) + ROT_W'(zcy_reg);
            ycp3_reg <= ycp_reg;
            ysp3_reg <= ysp_reg;
            // pitch products of rotated z
            zsp_reg  <= ZP_W'(zr3_reg) * ZP_W'(cfg.sin_pitch);
            zcp_reg  <= ZP_W'(zr3_reg) * ZP_W'(cfg.cos_pitch);
            xr4_reg  <= xr3_reg;
            ycp4_reg <= ycp3_reg;
            ysp4_reg <= ysp3_reg;
            // back to q14
            xr5_reg  <= xr4_reg;
            yr5_reg  <= ysum[DEP_W+FRAC-1:FRAC];
            dr5_reg  <= dsum[DEP_W+FRAC-1:FRAC];
        end
    end

    assign out_valid = v_reg[4];
    assign xr        = xr5_reg;
    assign yr        = yr5_reg;
    assign dr        = dr5_reg;

endmodule

// ===== rtl/ppp_scl.sv =====
// viewer distance scaling and sign / magnitude split for the divider
// depends on ppp_pkg
module ppp_scl (
    input  logic                              clk,
    input  logic                              rstn,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [ppp_pkg::ROT_W-1:0]  xr,
    input  logic signed [ppp_pkg::DEP_W-1:0]  yr,
    input  logic signed [ppp_pkg::DEP_W-1:0]  dr,
    input  logic [ppp_pkg::VD_W-1:0]          vd,
    output logic                              out_valid,
    output logic [ppp_pkg::NUM_W-1:0]         num_x,
    output logic [ppp_pkg::NUM_W-1:0]         num_y,
    output logic [ppp_pkg::DEP_W-1:0]         den,
    output ppp_pkg::side_t                    side
);
    import ppp_pkg::*;

    logic [1:0] v_reg;

    logic signed [NUM_W-1:0] nx_reg, ny_reg;
    logic signed [DEP_W-1:0] dr6_reg;
    logic [NUM_W-1:0]        ax_reg, ay_reg;
    logic [DEP_W-1:0]        ad_reg;
    side_t                   side_reg;

    logic                    nx_neg, ny_neg, d_neg;
    logic [NUM_W-1:0]        ax_next, ay_next, dsh;
    logic [DEP_W-1:0]        ad_next;
    side_t                   side_next;

    always_ff @(posedge clk) begin
        if (!rstn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[0], in_valid};
        end
    end

    always_comb begin
        nx_neg  = nx_reg[NUM_W-1];
        ny_neg  = ny_reg[NUM_W-1];
        d_neg   = dr6_reg[DEP_W-1];
        ax_next = nx_neg ? NUM_W'(-nx_reg) : NUM_W'(nx_reg);
        ay_next = ny_neg ? NUM_W'(-ny_reg) : NUM_W'(ny_reg);
        ad_next = d_neg ? DEP_W'(-dr6_reg) : DEP_W'(dr6_reg);
        dsh     = NUM_W'(ad_next) << QUO_B;
        side_next.zero  = (dr6_reg == '0);
        side_next.bad   = d_neg || (dr6_reg == '0);
        side_next.neg_x = nx_neg ^ d_neg;
        side_next.neg_y = ny_neg ^ d_neg;
        side_next.ovf_x = (ax_next >= dsh);
        side_next.ovf_y = (ay_next >= dsh);
    end

    always_ff @(posedge clk) begin
        if (en) begin
            nx_reg   <= NUM_W'(xr) * NUM_W'($signed({1'b0, vd}));
            ny_reg   <= NUM_W'(yr) * NUM_W'($signed({1'b0, vd}));
            dr6_reg  <= dr;
            ax_reg   <= ax_next;
            ay_reg   <= ay_next;
            ad_reg   <= ad_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = v_reg[1];
    assign num_x     = ax_reg;
    assign num_y     = ay_reg;
    assign den       = ad_reg;
    assign side      = side_reg;

endmodule

// ===== rtl/ppp_div.sv =====
// restoring divider, one quotient bit per stage, x and y share the divisor
// depends on ppp_pkg
module ppp_div (
    input  logic                          clk,
    input  logic                          rstn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [ppp_pkg::NUM_W-1:0]     num_x,
    input  logic [ppp_pkg::NUM_W-1:0]     num_y,
    input  logic [ppp_pkg::DEP_W-1:0]     den,
    input  ppp_pkg::side_t                side_in,
    output logic                          out_valid,
    output logic [ppp_pkg::QUO_B-1:0]     q_x,
    output logic [ppp_pkg::QUO_B-1:0]     q_y,
    output ppp_pkg::side_t                side_out
);
    import ppp_pkg::*;

    logic [QUO_B-1:0] v_reg;
    logic [NUM_W-1:0] rx_reg   [QUO_B];
    logic [NUM_W-1:0] ry_reg   [QUO_B];
    logic [DEP_W-1:0] dn_reg   [QUO_B];
    logic [QUO_B-1:0] qx_reg   [QUO_B];
    logic [QUO_B-1:0] qy_reg   [QUO_B];
    side_t            sd_reg   [QUO_B];

    logic [NUM_W-1:0] rx_next  [QUO_B];
    logic [NUM_W-1:0] ry_next  [QUO_B];
    logic [DEP_W-1:0] dn_next  [QUO_B];
    logic [QUO_B-1:0] qx_next  [QUO_B];
    logic [QUO_B-1:0] qy_next  [QUO_B];
    side_t            sd_next  [QUO_B];

    always_ff @(posedge clk) begin
        if (!rstn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[QUO_B-2:0], in_valid};
        end
    end

    // stage k decides quotient bit QUO_B-1-k
    always_comb begin
        logic [NUM_W-1:0] rx_c, ry_c, dsh;
        logic [DEP_W-1:0] dn_c;
        logic [QUO_B-1:0] qx_c, qy_c;
        logic             gx, gy;
        for (int k = 0; k < QUO_B; k++) begin
            if (k == 0) begin
                rx_c = num_x;
                ry_c = num_y;
                dn_c = den;
                qx_c = '0;
                qy_c = '0;
                sd_next[k] = side_in;
            end else begin
                rx_c = rx_reg[k-1];
                ry_c = ry_reg[k-1];
                dn_c = dn_reg[k-1];
                qx_c = qx_reg[k-1];
                qy_c = qy_reg[k-1];
                sd_next[k] = sd_reg[k-1];
            end
            dsh = NUM_W'(dn_c) << (QUO_B - 1 - k);
            gx  = (rx_c >= dsh);
            gy  = (ry_c >= dsh);
            rx_next[k] = gx ? rx_c - dsh : rx_c;
            ry_next[k] = gy ? ry_c - dsh : ry_c;
            dn_next[k] = dn_c;
            qx_next[k] = {qx_c[QUO_B-2:0], gx};
            qy_next[k] = {qy_c[QUO_B-2:0], gy};
        end
    end

    always_ff @(posedge clk) begin
        if (en) begin
            for (int k = 0; k < QUO_B; k++) begin
                rx_reg[k] <= rx_next[k];
                ry_reg[k] <= ry_next[k];
                dn_reg[k] <= dn_next[k];
                qx_reg[k] <= qx_next[k];
                qy_reg[k] <= qy_next[k];
                sd_reg[k] <= sd_next[k];
            end
        end
    end

    assign out_valid = v_reg[QUO_B-1];
    assign q_x       = qx_reg[QUO_B-1];
    assign q_y       = qy_reg[QUO_B-1];
    assign side_out  = sd_reg[QUO_B-1];

endmodule

// ===== rtl/perspective_point_projector_top.sv =====
// pipeline: 5 rotate, 2 scale, 18 divide and 1 output stage from input item to result
// throughput: one item per cycle while the skid slot is empty; the divider retires one quotient bit per stage
// the output register plus a one-item skid keeps s_ready free of m_ready
// reset: synchronous active-low aresetn clears all valid bits and loads register defaults
// depends on ppp_pkg, ppp_rot, ppp_scl, ppp_div
module perspective_point_projector_top #(
    parameter int SCREEN_WIDTH  = ppp_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = ppp_pkg::SCREEN_HEIGHT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input channel: one world point per item
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [ppp_pkg::PT_W-1:0]   s_point_x,
    input  logic signed [ppp_pkg::PT_W-1:0]   s_point_y,
    input  logic signed [ppp_pkg::PT_W-1:0]   s_point_z,
    // result channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [ppp_pkg::OUT_W-1:0]  m_screen_x,
    output logic signed [ppp_pkg::OUT_W-1:0]  m_screen_y,
    output logic                              m_depth_bad,
    // configuration writes, only while idle
    input  logic                              cfg_we,
    input  ppp_pkg::reg_idx_t                 cfg_index,
    input  logic [ppp_pkg::CFG_W-1:0]         cfg_wdata
);
    import ppp_pkg::*;

    // screen center, remainder dropped
    localparam logic signed [OSUM_W-1:0] CENTER_X = OSUM_W'(SCREEN_WIDTH / 2);
    localparam logic signed [OSUM_W-1:0] CENTER_Y = OSUM_W'(SCREEN_HEIGHT / 2);
    localparam logic signed [OUT_W-1:0]  OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0]  OUT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};

    // clamp a small signed sum to the 16 bit result range
    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [OSUM_W-1:0] v);
        logic signed [OSUM_W-1:0] hi, lo;
        hi = OSUM_W'(OUT_MAX);
        lo = OSUM_W'(OUT_MIN);
        if (v > hi) begin
            return OUT_MAX;
        end else if (v < lo) begin
            return OUT_MIN;
        end else begin
            return v[OUT_W-1:0];
        end
    endfunction

    // configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cos_yaw   <= TRIG_W'(16384);
            cfg_reg.sin_yaw   <= '0;
            cfg_reg.cos_pitch <= TRIG_W'(16384);
            cfg_reg.sin_pitch <= '0;
            cfg_reg.cam_x     <= '0;
            cfg_reg.cam_y     <= '0;
            cfg_reg.cam_z     <= -PT_W'(500);
            cfg_reg.view_dist <= VD_W'(256);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_COS_YAW:   cfg_reg.cos_yaw   <= cfg_wdata[TRIG_W-1:0];
                REG_SIN_YAW:   cfg_reg.sin_yaw   <= cfg_wdata[TRIG_W-1:0];
                REG_COS_PITCH: cfg_reg.cos_pitch <= cfg_wdata[TRIG_W-1:0];
                REG_SIN_PITCH: cfg_reg.sin_pitch <= cfg_wdata[TRIG_W-1:0];
                REG_CAM_X:     cfg_reg.cam_x     <= cfg_wdata[PT_W-1:0];
                REG_CAM_Y:     cfg_reg.cam_y     <= cfg_wdata[PT_W-1:0];
                REG_CAM_Z:     cfg_reg.cam_z     <= cfg_wdata[PT_W-1:0];
                REG_VIEW_DIST: cfg_reg.view_dist <= cfg_wdata[VD_W-1:0];
                default: ;
            endcase
        end
    end

    // whole pipeline advances together unless the skid slot is taken
    logic pipe_en;
    logic k_valid_reg;

    assign pipe_en = !k_valid_reg;
    assign s_ready = pipe_en;

    // rotation
    logic                     rot_valid;
    logic signed [ROT_W-1:0]  rot_xr;
    logic signed [DEP_W-1:0]  rot_yr, rot_dr;

    ppp_rot u_rot (
        .clk       (aclk),
        .rstn      (aresetn),
        .en        (pipe_en),
        .in_valid  (s_valid && s_ready),
        .px        (s_point_x),
        .py        (s_point_y),
        .pz        (s_point_z),
        .cfg       (cfg_reg),
        .out_valid (rot_valid),
        .xr        (rot_xr),
        .yr        (rot_yr),
        .dr        (rot_dr)
    );

    // scaling by viewer distance
    logic             scl_valid;
    logic [NUM_W-1:0] scl_nx, scl_ny;
    logic [DEP_W-1:0] scl_den;
    side_t            scl_side;

    ppp_scl u_scl (
        .clk       (aclk),
        .rstn      (aresetn),
        .en        (pipe_en),
        .in_valid  (rot_valid),
        .xr        (rot_xr),
        .yr        (rot_yr),
        .dr        (rot_dr),
        .vd        (cfg_reg.view_dist),
        .out_valid (scl_valid),
        .num_x     (scl_nx),
        .num_y     (scl_ny),
        .den       (scl_den),
        .side      (scl_side)
    );

    // perspective divide
    logic             div_valid;
    logic [QUO_B-1:0] div_qx, div_qy;
    side_t            div_side;

    ppp_div u_div (
        .clk       (aclk),
        .rstn      (aresetn),
        .en        (pipe_en),
        .in_valid  (scl_valid),
        .num_x     (scl_nx),
        .num_y     (scl_ny),
        .den       (scl_den),
        .side_in   (scl_side),
        .out_valid (div_valid),
        .q_x       (div_qx),
        .q_y       (div_qy),
        .side_out  (div_side)
    );

    // sign, center and saturation
    logic signed [OSUM_W-1:0] qx_s, qy_s, sum_x, sum_y;
    logic signed [OUT_W-1:0]  res_x, res_y;

    always_comb begin
        qx_s  = div_side.neg_x ? -OSUM_W'(div_qx) : OSUM_W'(div_qx);
        // screen y is flipped, so the negated quotient goes in
        qy_s  = div_side.neg_y ? OSUM_W'(div_qy) : -OSUM_W'(div_qy);
        sum_x = qx_s + CENTER_X;
        sum_y = qy_s + CENTER_Y;
        if (div_side.zero) begin
            // zero depth: no projection, no center
            res_x = '0;
            res_y = '0;
        end else begin
            if (div_side.ovf_x) begin
                res_x = div_side.neg_x ? OUT_MIN : OUT_MAX;
            end else begin
                res_x = sat_out(sum_x);
            end
            if (div_side.ovf_y) begin
                res_y = div_side.neg_y ? OUT_MAX : OUT_MIN;
            end else begin
                res_y = sat_out(sum_y);
            end
        end
    end

    // output register and skid slot
    logic                    o_valid_reg;
    logic signed [OUT_W-1:0] o_x_reg, o_y_reg, k_x_reg, k_y_reg;
    logic                    o_bad_reg, k_bad_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_valid_reg <= 1'b0;
            k_valid_reg <= 1'b0;
        end else if (m_ready || !o_valid_reg) begin
            // output slot frees up: drain skid first, else take the pipe
            if (k_valid_reg) begin
                o_valid_reg <= 1'b1;
                k_valid_reg <= 1'b0;
            end else begin
                o_valid_reg <= div_valid;
            end
        end else if (div_valid) begin
            // output held, park the arriving item
            k_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_ready || !o_valid_reg) begin
            if (k_valid_reg) begin
                o_x_reg   <= k_x_reg;
                o_y_reg   <= k_y_reg;
                o_bad_reg <= k_bad_reg;
            end else begin
                o_x_reg   <= res_x;
                o_y_reg   <= res_y;
                o_bad_reg <= div_side.bad;
            end
        end else if (pipe_en) begin
            k_x_reg   <= res_x;
            k_y_reg   <= res_y;
            k_bad_reg <= div_side.bad;
        end
    end

    assign m_valid     = o_valid_reg;
    assign m_screen_x  = o_x_reg;
    assign m_screen_y  = o_y_reg;
    assign m_depth_bad = o_bad_reg;

endmodule

// ===== rtl/ppp_checker.sv =====
// port-level checks of the projector, bound onto the top level
// depends on ppp_pkg and assert_macros.svh
`include "assert_macros.svh"

module ppp_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic signed [ppp_pkg::PT_W-1:0]   s_point_x,
    input logic signed [ppp_pkg::PT_W-1:0]   s_point_y,
    input logic signed [ppp_pkg::PT_W-1:0]   s_point_z,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [ppp_pkg::OUT_W-1:0]  m_screen_x,
    input logic signed [ppp_pkg::OUT_W-1:0]  m_screen_y,
    input logic                              m_depth_bad,
    input logic                              cfg_we,
    input ppp_pkg::reg_idx_t                 cfg_index,
    input logic [ppp_pkg::CFG_W-1:0]         cfg_wdata
);

    // a stalled result keeps valid and payload
    `PPP_ASSERT(a_out_hold, (m_valid && !m_ready) |=> (m_valid && $stable(m_screen_x) && $stable(m_screen_y) && $stable(m_depth_bad)), "result changed while stalled")

    // nothing comes out right after reset
    `PPP_ASSERT_ALWAYS(a_reset_empty, !$past(aresetn) |-> !m_valid, "result valid right after reset")

    // input side backs up only behind a stalled result
    `PPP_ASSERT(a_ready_stall, !s_ready |-> $past(m_valid && !m_ready), "input not ready without output stall")

    // a waiting input item keeps valid and payload
    `PPP_ASSERT(a_in_hold, (s_valid && !s_ready) |=> (s_valid && $stable({s_point_x, s_point_y, s_point_z})), "input item changed while waiting")

    // registers are written only while no input is offered and no result is valid, with known index and data
    `PPP_ASSERT(a_cfg_idle, cfg_we |-> (!s_valid && !m_valid && !$isunknown({cfg_index, cfg_wdata})), "register write while items in flight")

endmodule

bind perspective_point_projector_top ppp_checker u_ppp_checker (.*);

// ===== tb/sv/testbench.sv =====
// self-checking testbench for perspective_point_projector_top
// predicts screen position and depth flag per point; depends on ppp_pkg and the rtl
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ppp_pkg::*;

    localparam int SCR_W = 640;
    localparam int SCR_H = 480;
    localparam int LATENCY = 26;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [PT_W-1:0] x;
        logic signed [PT_W-1:0] y;
        logic signed [PT_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic signed [OUT_W-1:0] sx;
        logic signed [OUT_W-1:0] sy;
        logic                    bad;
    } screen_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [PT_W-1:0] s_point_x = '0;
    logic signed [PT_W-1:0] s_point_y = '0;
    logic signed [PT_W-1:0] s_point_z = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [OUT_W-1:0] m_screen_x;
    logic signed [OUT_W-1:0] m_screen_y;
    logic m_depth_bad;
    logic cfg_we = 1'b0;
    reg_idx_t cfg_index = REG_COS_YAW;
    logic [CFG_W-1:0] cfg_wdata = '0;

    perspective_point_projector_top u_dut (.*);

    // predictor copy of the camera registers
    cfg_t cam;
    point_t pending_points[$];
    screen_t expected_screens[$];
    int mismatches = 0;
    longint cycle = 0;
    bit hold_sender = 1'b0;

    initial begin
        forever #6 aclk = ~aclk;
    end

    function automatic longint floor14(longint v);
        return v >>> 14;    // arithmetic shift floors toward minus infinity
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[OUT_W-1:0];
    endfunction

    // exact integer projection of one point with the current camera
    function automatic screen_t project_point(point_t p);
        screen_t r;
        longint cy, sy, cp, sp, vd, dx, dy, dz, xr, zr, yr, dr, qx, qy;
        cy = cam.cos_yaw; sy = cam.sin_yaw; cp = cam.cos_pitch; sp = cam.sin_pitch;
        vd = longint'(cam.view_dist);
        dx = longint'(p.x) - longint'(cam.cam_x);
        dy = longint'(p.y) - longint'(cam.cam_y);
        dz = longint'(p.z) - longint'(cam.cam_z);
        xr = dx * cy - dz * sy;
        zr = dx * sy + dz * cy;
        yr = floor14(dy * cp * 16384 + zr * sp);
        dr = floor14(zr * cp - dy * sp * 16384);
        r.bad = (dr <= 0);
        r.sx = '0;
        r.sy = '0;
        if (dr != 0) begin
            // magnitudes stay under 2^63; sv division truncates toward zero
            qx = (xr * vd) / dr;
            qy = (yr * vd) / dr;
            r.sx = clamp16(qx + SCR_W / 2);
            r.sy = clamp16(-qy + SCR_H / 2);
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle);
        mismatches++;
    endtask

    // driver: bursts with random gaps, payload held until accepted
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_screens.push_back(project_point({s_point_x, s_point_y, s_point_z}));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (pending_points.size() > 0 && !hold_sender) begin
                    point_t p;
                    p = pending_points.pop_front();
                    s_valid <= 1'b1;
                    s_point_x <= p.x;
                    s_point_y <= p.y;
                    s_point_z <= p.z;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(40, 1);
                        gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 0);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    int stall_phase = 0;
    always @(posedge aclk) begin
        cycle <= cycle + 1;
        if (aresetn) begin
            stall_phase <= stall_phase + 1;
            if (stall_phase[9:8] == 2'd0) m_ready <= 1'b1;    // stretch with no stalls
            else m_ready <= ($urandom_range(3, 0) != 0);
            if (m_valid && m_ready) begin
                if (expected_screens.size() == 0) begin
                    report_mismatch("unexpected item", 0, 0);
                end else begin
                    screen_t e;
                    e = expected_screens.pop_front();
                    if (m_screen_x !== e.sx) report_mismatch("screen_x", m_screen_x, e.sx);
                    if (m_screen_y !== e.sy) report_mismatch("screen_y", m_screen_y, e.sy);
                    if (m_depth_bad !== e.bad) report_mismatch("depth_bad", m_depth_bad, e.bad);
                end
            end
        end
        if (cycle > CYCLE_LIMIT) begin
            $display("timeout");
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic signed [PT_W-1:0] rand_coord();
        case ($urandom_range(3, 0))
            0: return PT_W'($urandom());                                          // full range
            1: return PT_W'($signed(20'($urandom_range(2000, 0))) - 1000);        // near origin
            2: return ($urandom_range(1, 0) != 0) ? 20'sh7ffff : 20'sh80000;
            default: return PT_W'($signed(20'($urandom_range(200000, 0))) - 100000);
        endcase
    endfunction

    function automatic point_t rand_point();
        point_t p;
        p.x = rand_coord();
        p.y = rand_coord();
        // mostly in front of the camera so the divide is exercised
        p.z = ($urandom_range(4, 0) != 0) ? PT_W'(cam.cam_z + $urandom_range(60000, 1))
                                          : rand_coord();
        return p;
    endfunction

    // wait until all queued points went out and all results came back
    task automatic drain();
        while (pending_points.size() > 0 || s_valid || expected_screens.size() > 0)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_COS_YAW:   cam.cos_yaw = val[TRIG_W-1:0];
            REG_SIN_YAW:   cam.sin_yaw = val[TRIG_W-1:0];
            REG_COS_PITCH: cam.cos_pitch = val[TRIG_W-1:0];
            REG_SIN_PITCH: cam.sin_pitch = val[TRIG_W-1:0];
            REG_CAM_X:     cam.cam_x = val[PT_W-1:0];
            REG_CAM_Y:     cam.cam_y = val[PT_W-1:0];
            REG_CAM_Z:     cam.cam_z = val[PT_W-1:0];
            default:       cam.view_dist = val[VD_W-1:0];
        endcase
    endtask

    task automatic rand_camera(bit extreme);
        int a;
        a = $urandom_range(16384, 0);
        write_reg(REG_COS_YAW, extreme ? 20'(-16384) : 20'(a));
        write_reg(REG_SIN_YAW, extreme ? 20'(16384) : 20'($signed($urandom_range(32768, 0)) - 16384));
        write_reg(REG_COS_PITCH, extreme ? 20'(16384) : 20'($urandom_range(16384, 8000)));
        write_reg(REG_SIN_PITCH, extreme ? 20'(-16384) : 20'($signed($urandom_range(16000, 0)) - 8000));
        write_reg(REG_CAM_X, extreme ? 20'h80000 : 20'($urandom()));
        write_reg(REG_CAM_Y, extreme ? 20'h7ffff : 20'($signed($urandom_range(2000, 0)) - 1000));
        write_reg(REG_CAM_Z, extreme ? 20'h80000 : 20'($signed($urandom_range(4000, 0)) - 2000));
        write_reg(REG_VIEW_DIST, extreme ? 20'hffff : 20'($urandom_range(65535, 1)));
    endtask

    initial begin
        point_t p;
        cam = '{cos_yaw: 16384, sin_yaw: 0, cos_pitch: 16384, sin_pitch: 0,
                cam_x: 0, cam_y: 0, cam_z: -500, view_dist: 256};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset camera, extremes, zero and negative depth, saturation
        pending_points.push_back('{0, 0, 0});
        pending_points.push_back('{100, -50, 0});
        pending_points.push_back('{0, 0, -500});          // depth exactly zero
        pending_points.push_back('{7, 9, -1000});         // behind the camera
        pending_points.push_back('{20'sh7ffff, 20'sh80000, -499});   // saturation
        pending_points.push_back('{20'sh80000, 20'sh7ffff, -499});
        pending_points.push_back('{20'sh7ffff, 20'sh7ffff, 20'sh7ffff});
        pending_points.push_back('{20'sh80000, 20'sh80000, 20'sh80000});
        pending_points.push_back('{-1, -1, -1});
        drain();
        // view_dist of zero; the extreme camera below brings the largest one
        write_reg(REG_VIEW_DIST, '0);
        pending_points.push_back('{1000, 1000, 1000});
        pending_points.push_back('{-1000, 5, -600});
        drain();
        rand_camera(1'b1);
        for (int i = 0; i < 10; i++) pending_points.push_back(rand_point());
        // point on the camera position, so the rotated depth is exactly zero, with tilted pitch
        pending_points.push_back('{20'sh80000, 20'sh7ffff, 20'sh80000});
        drain();

        for (int phase = 0; phase < 12; phase++) begin
            rand_camera(phase == 5);
            for (int i = 0; i < 160; i++) begin
                p = rand_point();
                pending_points.push_back(p);
            end
            if (phase == 3) begin
                // sender holds off until the pipeline is empty
                while (pending_points.size() > 80) @(posedge aclk);
                hold_sender = 1'b1;
                while (s_valid || expected_screens.size() > 0) @(posedge aclk);
                hold_sender = 1'b0;
            end
            drain();
        end
        if (mismatches == 0 && expected_screens.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// ===== perspective_point_projector_top.f =====
+incdir+rtl
rtl/ppp_pkg.sv
rtl/ppp_rot.sv
rtl/ppp_scl.sv
rtl/ppp_div.sv
rtl/perspective_point_projector_top.sv
rtl/ppp_checker.sv
tb/sv/testbench.sv
